// ===== hw/rtl/lueu_pkg.sv =====
// Shared types and constants for the LU element update engine.
package lueu_pkg;

  // Entry format and datapath widths
  localparam int DATA_W = 32;   // Q16.16 entry
  localparam int IDX_W  = 6;    // row / column port width
  localparam int PROD_W = 64;   // exact Q32.32 product
  localparam int RND_W  = 48;   // product rounded to Q.16
  localparam int ACC_W  = 54;   // sum of up to 63 rounded products
  localparam int NUM_W  = 55;   // entry minus sum

  // Clamp limits for the 32-bit result
  localparam logic signed [NUM_W-1:0] NUM_HI = 55'sh0_7FFF_FFFF;
  localparam logic signed [NUM_W-1:0] NUM_LO = -55'sh0_8000_0000;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_UPPER = 2'd1,
    OP_LOWER = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_ZDIV  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_SAT   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_LOAD,
    S_DOT,
    S_DRAIN,
    S_CALC,
    S_ABS,
    S_DIVCHK,
    S_DIV,
    S_FINISH
  } state_t;

endpackage

// ===== hw/rtl/lueu_store.sv =====
// Matrix store: one write port, two registered read ports.
module lueu_store #(
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [31:0]   rdata_a,
  output logic [31:0]   rdata_b
);

  localparam int DEPTH = 1 << AW;

  logic [31:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, registered
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hw/rtl/lu_element_update_engine.sv =====
// Top level: LU element update engine on a Q16.16 matrix store.
//
//  channel | direction | signals                              | handshake
//  --------+-----------+--------------------------------------+------------------
//  in      | input     | opcode, row, col, write_value        | in_valid/in_stall
//  out     | output    | entry_value, status                  | out_valid/out_stall
//  cfg     | input     | cfg_data (matrix_order)              | cfg_write
//
// Write, read and out-of-range items pass FETCH, LOAD and FINISH from accept to result.
// An upper update sums row product terms, a lower update sums col terms:
// one read pair per product term through the store's two read ports, then a
// 32-step restoring divider for the lower quotient, skipped for a zero diagonal or an oversized quotient.
// After reset a clearing pass writes zero to all 2^(2*clog2(MAX_ORDER))
// entries (4096 by default); in_stall stays high meanwhile.
// One item is in work at a time; a finished result waits in the output
// register while the next item is accepted and worked on.
module lu_element_update_engine #(
  parameter int MAX_ORDER = 64
) (
  input  logic        clk,
  input  logic        rst,
  // item input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [5:0]  row,
  input  logic [5:0]  col,
  input  logic signed [31:0] write_value,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] entry_value,
  output logic [1:0]  status,
  // configuration
  input  logic        cfg_write,
  input  logic [6:0]  cfg_data
);

  localparam int IDXW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int AW   = 2 * IDXW;

  localparam int ACC_W = lueu_pkg::ACC_W;
  localparam int NUM_W = lueu_pkg::NUM_W;
  localparam int RND_W = lueu_pkg::RND_W;

  function automatic logic [AW-1:0] addr_of(input logic [5:0] r, input logic [5:0] c);
    return {IDXW'(r), IDXW'(c)};
  endfunction

  lueu_pkg::state_t state, state_next;

  // config
  logic [6:0] matrix_order;
  logic [6:0] order_eff;

  // latched item
  lueu_pkg::opcode_t op_q;
  logic [5:0]        row_q, col_q, lim_q;
  logic signed [31:0] wv_q;
  logic              rng_q;

  // dot product pipeline
  logic [5:0]          k;
  logic                rd_vld, prod_vld, rnd_vld;
  logic signed [63:0]  prod;
  logic signed [RND_W-1:0] rnd;
  logic signed [ACC_W-1:0] acc;
  logic signed [31:0]  entry_rc, diag;
  logic signed [NUM_W-1:0] num;

  // divider
  logic [NUM_W-1:0] un;
  logic [31:0]      ud, rem, dlo, quo;
  logic [4:0]       dcnt;
  logic             neg, ovf;
  logic [32:0]      trial;
  logic             trial_ge;

  // store interface
  logic          mem_we;
  logic [AW-1:0] mem_waddr, clr_addr, raddr_a, raddr_b;
  logic [31:0]   mem_wdata, rd_a, rd_b;

  // result
  logic signed [31:0] res_val;
  lueu_pkg::status_t  res_st;
  logic               res_wr, out_free;

  lueu_store #(.AW(AW)) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // effective order, clipped to MAX_ORDER
  assign order_eff = (32'(matrix_order) > 32'(MAX_ORDER)) ? 7'(MAX_ORDER) : matrix_order;

  assign in_stall = (state != lueu_pkg::S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // read address selection
  always_comb begin
    if (state == lueu_pkg::S_DOT) begin
      raddr_a = addr_of(row_q, k);
      raddr_b = addr_of(k, col_q);
    end else begin
      raddr_a = addr_of(row_q, col_q);
      raddr_b = addr_of(col_q, col_q);
    end
  end

  // divider step
  assign trial    = {rem, dlo[31]};
  assign trial_ge = (trial >= {1'b0, ud});

  // final result
  always_comb begin
    res_val = entry_rc;
    res_st  = lueu_pkg::STAT_OK;
    res_wr  = 1'b0;
    case (op_q)
      lueu_pkg::OP_WRITE: begin
        res_val = wv_q;
        res_wr  = 1'b1;
      end
      lueu_pkg::OP_UPPER: begin
        res_wr = 1'b1;
        if (num > lueu_pkg::NUM_HI) begin
          res_val = 32'sh7FFF_FFFF;
          res_st  = lueu_pkg::STAT_SAT;
        end else if (num < lueu_pkg::NUM_LO) begin
          res_val = -32'sh7FFF_FFFF - 32'sd1;
          res_st  = lueu_pkg::STAT_SAT;
        end else begin
          res_val = num[31:0];
        end
      end
      lueu_pkg::OP_LOWER: begin
        if (diag == 32'sd0) begin
          res_st = lueu_pkg::STAT_ZDIV;
        end else begin
          res_wr = 1'b1;
          if (neg) begin
            if (ovf || quo > 32'h8000_0000) begin
              res_val = -32'sh7FFF_FFFF - 32'sd1;
              res_st  = lueu_pkg::STAT_SAT;
            end else begin
              res_val = $signed(32'h0 - quo);
            end
          end else begin
            if (ovf || quo[31]) begin
              res_val = 32'sh7FFF_FFFF;
              res_st  = lueu_pkg::STAT_SAT;
            end else begin
              res_val = $signed(quo);
            end
          end
        end
      end
      default: begin
        res_val = entry_rc;
      end
    endcase
    if (!rng_q) begin
      res_val = 32'sd0;
      res_st  = lueu_pkg::STAT_RANGE;
      res_wr  = 1'b0;
    end
  end

  // store write: clearing pass or write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_of(row_q, col_q);
    mem_wdata = res_val;
    if (state == lueu_pkg::S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = 32'h0;
    end else if (state == lueu_pkg::S_FINISH && out_free) begin
      mem_we = res_wr;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lueu_pkg::S_CLEAR: begin
        if (clr_addr == {AW{1'b1}}) state_next = lueu_pkg::S_IDLE;
      end
      lueu_pkg::S_IDLE: begin
        if (in_valid) state_next = lueu_pkg::S_FETCH;
      end
      lueu_pkg::S_FETCH: state_next = lueu_pkg::S_LOAD;
      lueu_pkg::S_LOAD: begin
        if (!rng_q || op_q == lueu_pkg::OP_WRITE || op_q == lueu_pkg::OP_READ) begin
          state_next = lueu_pkg::S_FINISH;
        end else if (op_q == lueu_pkg::OP_LOWER && rd_b == 32'h0) begin
          state_next = lueu_pkg::S_FINISH;
        end else if (lim_q == 6'd0) begin
          state_next = lueu_pkg::S_CALC;
        end else begin
          state_next = lueu_pkg::S_DOT;
        end
      end
      lueu_pkg::S_DOT: begin
        if (k == lim_q - 6'd1) state_next = lueu_pkg::S_DRAIN;
      end
      lueu_pkg::S_DRAIN: begin
        if (!rd_vld && !prod_vld && !rnd_vld) state_next = lueu_pkg::S_CALC;
      end
      lueu_pkg::S_CALC: begin
        state_next = (op_q == lueu_pkg::OP_UPPER) ? lueu_pkg::S_FINISH : lueu_pkg::S_ABS;
      end
      lueu_pkg::S_ABS: state_next = lueu_pkg::S_DIVCHK;
      lueu_pkg::S_DIVCHK: begin
        if (un >= NUM_W'({ud, 16'h0})) state_next = lueu_pkg::S_FINISH;
        else state_next = lueu_pkg::S_DIV;
      end
      lueu_pkg::S_DIV: begin
        if (dcnt == 5'd0) state_next = lueu_pkg::S_FINISH;
      end
      lueu_pkg::S_FINISH: begin
        if (out_free) state_next = lueu_pkg::S_IDLE;
      end
      default: state_next = lueu_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lueu_pkg::S_CLEAR;
      clr_addr     <= '0;
      matrix_order <= 7'd64;
      rd_vld       <= 1'b0;
      prod_vld     <= 1'b0;
      rnd_vld      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state    <= state_next;
      rd_vld   <= (state == lueu_pkg::S_DOT);
      prod_vld <= rd_vld;
      rnd_vld  <= prod_vld;
      if (state == lueu_pkg::S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (cfg_write) matrix_order <= cfg_data;
      // output register
      if (state == lueu_pkg::S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // item capture
    if (state == lueu_pkg::S_IDLE && in_valid) begin
      op_q  <= lueu_pkg::opcode_t'(opcode);
      row_q <= row;
      col_q <= col;
      wv_q  <= write_value;
      rng_q <= ({1'b0, row} < order_eff) && ({1'b0, col} < order_eff);
      lim_q <= (lueu_pkg::opcode_t'(opcode) == lueu_pkg::OP_UPPER) ? row : col;
    end
    // operand load
    if (state == lueu_pkg::S_LOAD) begin
      entry_rc <= $signed(rd_a);
      diag     <= $signed(rd_b);
      acc      <= '0;
      k        <= '0;
    end
    if (state == lueu_pkg::S_DOT) k <= k + 6'd1;
    // multiply, round, accumulate
    if (rd_vld) prod <= $signed(rd_a) * $signed(rd_b);
    if (prod_vld) rnd <= RND_W'((prod + 64'sd32768) >>> 16);
    if (rnd_vld) acc <= acc + ACC_W'(rnd);
    // numerator
    if (state == lueu_pkg::S_CALC) num <= NUM_W'(entry_rc) - NUM_W'(acc);
    // magnitudes and sign
    if (state == lueu_pkg::S_ABS) begin
      un  <= num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);
      ud  <= diag[31] ? $unsigned(-diag) : $unsigned(diag);
      neg <= num[NUM_W-1] ^ diag[31];
    end
    // quotient range check and divider setup
    if (state == lueu_pkg::S_DIVCHK) begin
      ovf  <= (un >= NUM_W'({ud, 16'h0}));
      rem  <= un[47:16];
      dlo  <= {un[15:0], 16'h0};
      quo  <= '0;
      dcnt <= 5'd31;
    end
    // restoring division, one quotient bit per cycle
    if (state == lueu_pkg::S_DIV) begin
      rem  <= trial_ge ? 32'(trial - {1'b0, ud}) : trial[31:0];
      dlo  <= {dlo[30:0], 1'b0};
      quo  <= {quo[30:0], trial_ge};
      dcnt <= dcnt - 5'd1;
    end
    // result load
    if (state == lueu_pkg::S_FINISH && out_free) begin
      entry_value <= res_val;
      status      <= res_st;
    end
  end

  // the product pipeline is empty when the numerator is formed
  assert property (@(posedge clk) disable iff (rst)
    state == lueu_pkg::S_CALC |-> !rd_vld && !prod_vld && !rnd_vld)
    else $error("numerator formed with products in flight");

  // the dot walk never reads past its limit
  assert property (@(posedge clk) disable iff (rst)
    state == lueu_pkg::S_DOT |-> k < lim_q)
    else $error("dot index past limit");

  // divider remainder stays below the divisor
  assert property (@(posedge clk) disable iff (rst)
    state == lueu_pkg::S_DIV |-> rem < ud)
    else $error("divider remainder out of range");

  // an out-of-range item never writes the store
  assert property (@(posedge clk) disable iff (rst)
    state == lueu_pkg::S_FINISH && !rng_q |-> !mem_we)
    else $error("store written for out-of-range item");

endmodule
